/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// RAS_ASSERT_IMP: same-cycle implication. RAS_ASSERT_NXT: next-cycle implication.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RAS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define RAS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define RAS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RAS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/ras_pkg.sv */
package ras_pkg;

    // default store depth
    localparam int DEPTH_DEF  = 1024;

    // field widths
    localparam int FUNC_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 10;
    localparam int AMT_W      = 32;
    localparam int WORD_W     = 32;
    localparam int STAT_W     = 2;
    localparam int FILL_W     = 11;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;

    // width of the modulo unit dividend (rotation magnitude)
    localparam int DVD_W      = 32;

    typedef logic [FUNC_W-1:0] t_func;
    typedef logic [STAT_W-1:0] t_status;

    // operation codes
    localparam t_func OP_PUSH   = 3'd0;
    localparam t_func OP_POP    = 3'd1;
    localparam t_func OP_READ   = 3'd2;
    localparam t_func OP_WRITE  = 3'd3;
    localparam t_func OP_ROTATE = 3'd4;

    // status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

endpackage

/* design/rotatable_array_store.sv */
// Store of signed 32-bit words with a fill count, one operation per transfer.
// Input stream (s_axis): tuser carries the operation, tdata the value, the
// position and the rotation amount. Output stream (m_axis): one result per
// operation with the word, the status and the fill count after it.
// Push, pop, read, write, unused codes and rotate of an empty store: done as
// the input transfer is taken; the finish state then puts the result in the
// output register once it is free, and only then is a new input accepted.
// Rotate: the amount is reduced modulo the fill count n by a bit-serial
// remainder unit, then the words are copied through a scratch memory and
// back, one word a cycle per memory port. A zero reduced shift skips the copy.
// s_axis_tready is high only while no operation is in progress.
// The output register holds a result until it is taken; the block accepts
// the next operation meanwhile and waits before delivering its result only
// while the previous one is still held.
// Synchronous reset empties the store (fill count zero) and drops any pending
// result; memory contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module rotatable_array_store import ras_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] value, [41:32] position, [73:42] amount, [79:74] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [2:0] func
    input  logic [FUNC_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] word_out, [33:32] status, [44:34] fill_count, [47:45] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_COPY1 = 3'd2;
    localparam logic [2:0] S_COPY2 = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    t_status               r_status, n_status;
    logic                  r_use_rd, n_use_rd;
    logic                  r_neg, n_neg;
    logic [CW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_src, n_src;
    logic                  r_pend, n_pend;
    logic [AW-1:0]         r_pend_addr, n_pend_addr;
    logic                  r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;

    logic [WORD_W-1:0]     r_word_mem [DEPTH];
    logic [WORD_W-1:0]     r_scratch_mem [DEPTH];
    logic [WORD_W-1:0]     r_rd_word;
    logic [WORD_W-1:0]     r_sc_word;

    logic                  word_re, word_we, sc_re, sc_we;
    logic [AW-1:0]         word_ra, word_wa, sc_ra;
    logic [WORD_W-1:0]     word_wd;

    t_func                 in_func;
    logic [VALUE_W-1:0]    in_value;
    logic [POS_W-1:0]      in_pos;
    logic [AMT_W-1:0]      in_amount;
    logic                  in_acc;
    logic [XW-1:0]         pos_ext;
    logic                  pos_ok;
    logic [CW-1:0]         cnt_dec;

    logic                  div_start, div_done;
    logic [DVD_W-1:0]      div_mag;
    logic [CW-1:0]         div_rem;
    logic [CW-1:0]         shift;
    logic [AW-1:0]         src_inc;
    logic [WORD_W-1:0]     out_word;

    // unpack input transfer
    assign in_func   = s_axis_tuser;
    assign in_value  = s_axis_tdata[31:0];
    assign in_pos    = s_axis_tdata[41:32];
    assign in_amount = s_axis_tdata[73:42];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // index checks
    assign pos_ext = XW'(in_pos);
    assign pos_ok  = (pos_ext < XW'(r_count));
    assign cnt_dec = r_count - 1'b1;

    // rotation magnitude; the most negative amount gives 2^31 exactly
    assign div_mag = in_amount[AMT_W-1] ? (DVD_W'(0) - in_amount) : in_amount;

    ras_mod_unit #(
        .CW (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_mag),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // right turn by r is a left turn by n - r
    assign shift = r_neg ? ((div_rem == '0) ? '0 : (r_count - div_rem)) : div_rem;

    // source index wraps at the fill count
    assign src_inc  = ((CW'(r_src) + CW'(1)) == r_count) ? '0 : (r_src + 1'b1);

    assign out_word = r_use_rd ? r_rd_word : '0;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_status    = r_status;
        n_use_rd    = r_use_rd;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_src       = r_src;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        word_re     = 1'b0;
        word_ra     = '0;
        word_we     = 1'b0;
        word_wa     = '0;
        word_wd     = in_value;
        sc_re       = 1'b0;
        sc_ra       = '0;
        sc_we       = 1'b0;
        div_start   = 1'b0;

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_status = ST_OK;
                    n_use_rd = 1'b0;
                    n_state  = S_FIN;
                    case (in_func)
                        OP_PUSH: begin
                            if (r_count >= DEPTH_C) begin
                                n_status = ST_FULL;
                            end else begin
                                word_we = 1'b1;
                                word_wa = r_count[AW-1:0];
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count  = cnt_dec;
                                word_re  = 1'b1;
                                word_ra  = cnt_dec[AW-1:0];
                                n_use_rd = 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (!pos_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                word_re  = 1'b1;
                                word_ra  = pos_ext[AW-1:0];
                                n_use_rd = 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            if (!pos_ok) begin
                                n_status = ST_RANGE;
                            end else begin
                                word_we = 1'b1;
                                word_wa = pos_ext[AW-1:0];
                            end
                        end
                        OP_ROTATE: begin
                            if (r_count != '0) begin
                                div_start = 1'b1;
                                n_neg     = in_amount[AMT_W-1];
                                n_state   = S_DIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_src   = shift[AW-1:0];
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = (shift == '0) ? S_FIN : S_COPY1;
                end
            end
            S_COPY1: begin
                // store -> scratch, reading from the shifted source
                sc_we = r_pend;
                if (r_idx != r_count) begin
                    word_re     = 1'b1;
                    word_ra     = r_src;
                    n_src       = src_inc;
                    n_idx       = r_idx + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_idx   = '0;
                        n_state = S_COPY2;
                    end
                end
            end
            S_COPY2: begin
                // scratch -> store, in order
                word_we = r_pend;
                word_wa = r_pend_addr;
                word_wd = r_sc_word;
                if (r_idx != r_count) begin
                    sc_re       = 1'b1;
                    sc_ra       = r_idx[AW-1:0];
                    n_idx       = r_idx + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_idx[AW-1:0];
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                // hand the result to the output register once it is free
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = OUT_DATA_W'({FILL_W'(r_count), r_status, out_word});
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_use_rd    <= n_use_rd;
        r_neg       <= n_neg;
        r_src       <= n_src;
        r_pend_addr <= n_pend_addr;
        r_m_data    <= n_m_data;
    end

    // word store
    always_ff @(posedge i_clk) begin
        if (word_we) begin
            r_word_mem[word_wa] <= word_wd;
        end
        if (word_re) begin
            r_rd_word <= r_word_mem[word_ra];
        end
    end

    // scratch store
    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            r_scratch_mem[r_pend_addr] <= r_rd_word;
        end
        if (sc_re) begin
            r_sc_word <= r_scratch_mem[sc_ra];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `RAS_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C)
    `RAS_ASSERT_NXT(a_push_grows, i_clk, i_rst_n, in_acc && (in_func == OP_PUSH) && (r_count < DEPTH_C), r_count == ($past(r_count) + 1'b1))
    `RAS_ASSERT_NXT(a_copy_count_stable, i_clk, i_rst_n, (r_state == S_COPY1) || (r_state == S_COPY2), $stable(r_count))

endmodule

/* design/ras_mod_unit.sv */
`include "assert_macros.svh"

// Restoring remainder unit: one dividend bit per cycle.
module ras_mod_unit import ras_pkg::*; #(
    parameter int CW = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [CW-1:0]    i_divisor,
    output logic             o_done,
    output logic [CW-1:0]    o_rem
);

    localparam int SW = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [SW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [CW-1:0]    r_div;
    logic [CW-1:0]    r_rem;

    logic [CW:0]      trial;
    logic [CW:0]      diff;
    logic             geq;

    // one restoring step
    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign geq   = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= geq ? diff[CW-1:0] : trial[CW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `RAS_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_done, r_rem < r_div)
    `RAS_ASSERT_NXT(a_done_after_last, i_clk, i_rst_n, r_busy && (r_cnt == '0) && !i_start, r_done)
    `RAS_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, r_done, !r_busy)

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ras_pkg::*;

    localparam int    DEPTH           = DEPTH_DEF;
    localparam int    RANDOM_OPS      = 1725;
    localparam int    QUIET_LIMIT     = 10000;
    localparam int    HOLD_CYCLES     = 400;
    localparam int    DRAIN_CYCLES    = 50;
    localparam int    IN_PAD_W        = IN_DATA_W - VALUE_W - POS_W - AMT_W;
    localparam t_func OP_UNUSED_FIRST = 3'd5;

    localparam logic [31:0] CORNER_WORDS [4] =
        '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};

    typedef struct {
        t_func                     func;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
        logic signed [AMT_W-1:0]   amount;
    } t_op;

    typedef struct {
        logic signed [WORD_W-1:0] word;
        t_status                  status;
        logic [FILL_W-1:0]        fill;
    } t_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [31:0] value, [41:32] position, [73:42] amount, [79:74] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [2:0] func
    logic [FUNC_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [31:0] word_out, [33:32] status, [44:34] fill_count, [47:45] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // operations waiting to be offered, and results owed by the block
    t_op     op_queue [$];
    t_result due_results [$];
    t_op     cur_op;
    int      total_ops;
    int      gen_fill;

    // shadow of the store contents
    logic [WORD_W-1:0] word_mem [DEPTH];
    logic [WORD_W-1:0] turn_buf [DEPTH];
    int unsigned       fill_now = 0;

    // run statistics
    int ops_taken     = 0;
    int results_seen  = 0;
    int error_count   = 0;
    int rotations     = 0;
    int peak_fill     = 0;
    int full_hits     = 0;
    int empty_hits    = 0;
    int range_hits    = 0;
    int quiet_cycles  = 0;

    rotatable_array_store #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one operation to the shadow store and give the result it owes
    function automatic t_result store_apply(t_op op);
        t_result     res;
        int unsigned n;
        int unsigned shift;
        int unsigned r;
        logic [31:0] mag;
        res.word   = '0;
        res.status = ST_OK;
        case (op.func)
            OP_PUSH: begin
                if (fill_now >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    word_mem[fill_now] = op.value;
                    fill_now++;
                end
            end
            OP_POP: begin
                if (fill_now == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    fill_now--;
                    res.word = word_mem[fill_now];
                end
            end
            OP_READ: begin
                if (op.position >= fill_now) begin
                    res.status = ST_RANGE;
                end else begin
                    res.word = word_mem[op.position];
                end
            end
            OP_WRITE: begin
                if (op.position >= fill_now) begin
                    res.status = ST_RANGE;
                end else begin
                    word_mem[op.position] = op.value;
                end
            end
            OP_ROTATE: begin
                if (fill_now != 0) begin
                    n = fill_now;
                    // negative amounts turn right; magnitude taken as unsigned
                    if (op.amount < 0) begin
                        mag   = 32'd0 - op.amount;
                        r     = mag % n;
                        shift = (r == 0) ? 0 : n - r;
                    end else begin
                        shift = $unsigned(op.amount) % n;
                    end
                    if (shift != 0) begin
                        for (int unsigned i = 0; i < n; i++) begin
                            turn_buf[i] = word_mem[(i + shift) % n];
                        end
                        for (int unsigned i = 0; i < n; i++) begin
                            word_mem[i] = turn_buf[i];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.fill = fill_now[FILL_W-1:0];
        return res;
    endfunction

    function automatic void add_op(t_func f, logic signed [31:0] v, logic [POS_W-1:0] p,
                                   logic signed [31:0] a);
        t_op op;
        op.func     = f;
        op.value    = v;
        op.position = p;
        op.amount   = a;
        op_queue.insert(op_queue.size(), op);
        if (f == OP_PUSH && gen_fill < DEPTH) begin
            gen_fill++;
        end else if (f == OP_POP && gen_fill > 0) begin
            gen_fill--;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR: result %0d %s: got %0h, expected %0h", results_seen, what, got, want);
        error_count++;
    endtask

    // stimulus, reset and end of run
    initial begin : stimulus
        t_func             f;
        logic signed [31:0] v;
        logic signed [31:0] a;
        logic [POS_W-1:0]  p;
        int                roll;
        int                at_full;
        bit                growing;
        gen_fill = 0;

        // empty store corner cases
        add_op(OP_POP,    32'd0,       10'd0, 32'd0);
        add_op(OP_READ,   32'd0,       10'd0, 32'd0);
        add_op(OP_WRITE,  32'h1234,    10'd0, 32'd0);
        add_op(OP_ROTATE, 32'd0,       10'd0, 32'd5);
        // field extremes
        add_op(OP_PUSH,   32'h7FFF_FFFF, 10'd0, 32'd0);
        add_op(OP_PUSH,   32'h8000_0000, 10'd0, 32'd0);
        add_op(OP_PUSH,   32'h0000_0000, 10'd0, 32'd0);
        add_op(OP_PUSH,   32'hFFFF_FFFF, 10'd0, 32'd0);
        add_op(OP_PUSH,   32'd12345,     10'd0, 32'd0);
        add_op(OP_READ,   32'd0,         10'd4, 32'd0);
        add_op(OP_READ,   32'd0,         10'd5, 32'd0);
        add_op(OP_READ,   32'd0,         10'd1023, 32'd0);
        add_op(OP_WRITE,  32'hA5A5_A5A5, 10'd2, 32'd0);
        add_op(OP_WRITE,  32'h5A5A_5A5A, 10'd1023, 32'd0);
        // left, right, most negative, largest, and a multiple of the count
        add_op(OP_ROTATE, 32'd0, 10'd0, 32'd2);
        add_op(OP_ROTATE, 32'd0, 10'd0, 32'hFFFF_FFFF);
        add_op(OP_ROTATE, 32'd0, 10'd0, 32'h8000_0000);
        add_op(OP_ROTATE, 32'd0, 10'd0, 32'h7FFF_FFFF);
        add_op(OP_ROTATE, 32'd0, 10'd0, 32'd5);
        // unused codes do nothing
        for (int k = 0; k < 3; k++) begin
            add_op(OP_UNUSED_FIRST + t_func'(k), 32'hFFFF_FFFF, 10'd1023, 32'h8000_0000);
        end
        add_op(OP_READ, 32'd0, 10'd0, 32'd0);
        add_op(OP_POP,  32'd0, 10'd0, 32'd0);

        // random part: fill up to full first, then a pop-leaning mix
        growing = 1'b1;
        at_full = 0;
        for (int k = 0; k < RANDOM_OPS; k++) begin
            roll = $urandom_range(0, 99);
            if (growing) begin
                if (gen_fill == DEPTH) at_full++;
                if (at_full > 40) growing = 1'b0;
                f = (roll < 90) ? OP_PUSH  :
                    (roll < 92) ? OP_POP   :
                    (roll < 95) ? OP_READ  :
                    (roll < 97) ? OP_WRITE :
                    (roll < 99) ? OP_ROTATE :
                                  OP_UNUSED_FIRST + t_func'($urandom_range(0, 2));
            end else begin
                f = (roll < 15) ? OP_PUSH  :
                    (roll < 60) ? OP_POP   :
                    (roll < 74) ? OP_READ  :
                    (roll < 87) ? OP_WRITE :
                    (roll < 98) ? OP_ROTATE :
                                  OP_UNUSED_FIRST + t_func'($urandom_range(0, 2));
            end

            v = ($urandom_range(0, 9) == 0) ? CORNER_WORDS[$urandom_range(0, 3)] : $urandom;

            // mostly valid positions, some anywhere in the field
            if (gen_fill > 0 && $urandom_range(0, 99) < 85) begin
                p = $urandom_range(0, gen_fill - 1);
            end else begin
                p = $urandom_range(0, 1023);
            end

            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                a = int'($urandom_range(0, 2 * gen_fill + 2)) - gen_fill - 1;
            end else if (roll < 85) begin
                a = $urandom;
            end else begin
                a = CORNER_WORDS[$urandom_range(0, 3)];
            end
            add_op(f, v, p, a);
        end
        total_ops = op_queue.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_taken < total_ops) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d operations with %0d rotations; fill peaked at %0d of %0d.",
                 ops_taken, rotations, peak_fill, DEPTH);
        $display("Flagged results: %0d full, %0d empty, %0d index out of range.",
                 full_hits, empty_hits, range_hits);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // sender: offers queued operations, predicts each one as it transfers
    always @(posedge i_clk) begin : feed_ops
        t_result res;
        bit      pause;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                res = store_apply(cur_op);
                due_results.insert(due_results.size(), res);
                ops_taken++;
                if (cur_op.func == OP_ROTATE) rotations++;
                if (res.status == ST_FULL) full_hits++;
                if (res.status == ST_EMPTY) empty_hits++;
                if (res.status == ST_RANGE) range_hits++;
                if (int'(res.fill) > peak_fill) peak_fill = int'(res.fill);
            end
            // no idling for a stretch in the middle of the run
            pause = (ops_taken < 500 || ops_taken >= 800) && ($urandom_range(0, 99) < 19);
            if (op_queue.size() != 0 && !pause) begin
                cur_op = op_queue.pop_front();
                s_axis_tdata  <= {{IN_PAD_W{1'b0}}, cur_op.amount, cur_op.position,
                                  cur_op.value};
                s_axis_tuser  <= cur_op.func;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each result transfer, stalls at random and once for long
    always @(posedge i_clk) begin : check_results
        t_result                  want;
        logic signed [WORD_W-1:0] got_word;
        t_status                  got_status;
        logic [FILL_W-1:0]        got_fill;
        bit                       ready_nxt;
        int                       hold_left;
        bit                       hold_done;
        if (!i_rst_n) begin
            hold_left = 0;
            hold_done = 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_word   = m_axis_tdata[WORD_W-1:0];
                got_status = m_axis_tdata[WORD_W +: STAT_W];
                got_fill   = m_axis_tdata[WORD_W+STAT_W +: FILL_W];
                if (due_results.size() == 0) begin
                    report_mismatch("arrived with nothing outstanding", got_word, 32'd0);
                end else begin
                    want = due_results.pop_front();
                    if (got_word !== want.word) report_mismatch("word", got_word, want.word);
                    if (got_status !== want.status) begin
                        report_mismatch("status", 32'(got_status), 32'(want.status));
                    end
                    if (got_fill !== want.fill) begin
                        report_mismatch("fill", 32'(got_fill), 32'(want.fill));
                    end
                end
                results_seen++;
            end

            if (hold_left > 0) begin
                hold_left--;
                ready_nxt = 1'b0;
            end else if (!hold_done && results_seen >= 300) begin
                // long back-pressure so the block fills and stalls its input
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                ready_nxt = 1'b0;
            end else if (results_seen >= 600 && results_seen < 900) begin
                ready_nxt = 1'b1;
            end else begin
                ready_nxt = ($urandom_range(0, 99) >= 19);
            end
            m_axis_tready <= ready_nxt;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
